[rtl/spq_pkg.sv]
// shared types, codes and constants of the sorted priority queue
package spq_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned DataW         = 32;
  localparam int unsigned OccW          = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the input transaction
    logic exec;   // apply the operation and write the result register
  } dp_cmd_t;

endpackage

[rtl/spq_ctrl.sv]
// controller of the sorted priority queue: handshakes and sequencing
module spq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output spq_pkg::dp_cmd_t cmd_o
);
  import spq_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  // result register can take a new result
  assign slot_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (in_valid_i) state_d = CS_EXEC;
      end
      CS_EXEC: begin
        if (slot_free) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // outputs and result valid
  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      CS_EXEC: begin
        cmd_o.exec = slot_free;
        if (slot_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/spq_datapath.sv]
// datapath of the sorted priority queue: shift-register cells and result register
module spq_datapath #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QueueDepthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  spq_pkg::dp_cmd_t                    cmd_i,
  input  logic                                command_i,
  input  logic signed [spq_pkg::DataW-1:0]    item_value_i,
  input  logic signed [spq_pkg::DataW-1:0]    item_priority_i,
  output logic [1:0]                          status_o,
  output logic signed [spq_pkg::DataW-1:0]    head_value_o,
  output logic signed [spq_pkg::DataW-1:0]    head_priority_o,
  output logic [spq_pkg::OccW-1:0]            occupancy_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  // captured transaction
  cmd_e                     cmd_q;
  logic signed [DataW-1:0]  val_q;
  logic signed [DataW-1:0]  prio_in_q;

  // cells and fill count
  logic signed [DataW-1:0]  cell_prio_q [QUEUE_DEPTH];
  logic signed [DataW-1:0]  cell_val_q  [QUEUE_DEPTH];
  logic signed [DataW-1:0]  cell_prio_d [QUEUE_DEPTH];
  logic signed [DataW-1:0]  cell_val_d  [QUEUE_DEPTH];
  logic [CntW-1:0]          count_q, count_d;

  // result register
  status_e                  status_q, status_d;
  logic signed [DataW-1:0]  hv_q, hv_d;
  logic signed [DataW-1:0]  hp_q, hp_d;
  logic [OccW-1:0]          occ_q;

  logic                     is_empty, is_full, head_gt;
  logic [QUEUE_DEPTH-1:0]   ins_at;

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CntW'(QUEUE_DEPTH));
  assign head_gt  = is_empty || (cell_prio_q[0] > prio_in_q);

  // per-cell insert flags: insert position is at or before this cell
  always_comb begin
    ins_at[0] = head_gt;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      ins_at[i] = head_gt || (CntW'(i) >= count_q) || (cell_prio_q[i] >= prio_in_q);
    end
  end

  // next cell contents, count and result
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_prio_d[i] = cell_prio_q[i];
      cell_val_d[i]  = cell_val_q[i];
    end
    count_d  = count_q;
    status_d = STAT_OK;
    hv_d     = '0;
    hp_d     = '0;
    case (cmd_q)
      CMD_INSERT: begin
        if (is_full) begin
          status_d = STAT_FULL;
        end else begin
          count_d = count_q + 1'b1;
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i > 0 && ins_at[(i > 0) ? i - 1 : 0]) begin
              cell_prio_d[i] = cell_prio_q[(i > 0) ? i - 1 : 0];
              cell_val_d[i]  = cell_val_q[(i > 0) ? i - 1 : 0];
            end else if (ins_at[i]) begin
              cell_prio_d[i] = prio_in_q;
              cell_val_d[i]  = val_q;
            end
          end
        end
      end
      CMD_REMOVE: begin
        if (is_empty) begin
          status_d = STAT_EMPTY;
        end else begin
          hv_d    = cell_val_q[0];
          hp_d    = cell_prio_q[0];
          count_d = count_q - 1'b1;
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            cell_prio_d[i] = cell_prio_q[i + 1];
            cell_val_d[i]  = cell_val_q[i + 1];
          end
        end
      end
      default: ;
    endcase
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  // capture, cells and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q     <= cmd_e'(command_i);
      val_q     <= item_value_i;
      prio_in_q <= item_priority_i;
    end
    if (cmd_i.exec) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        cell_prio_q[i] <= cell_prio_d[i];
        cell_val_q[i]  <= cell_val_d[i];
      end
      status_q <= status_d;
      hv_q     <= hv_d;
      hp_q     <= hp_d;
      occ_q    <= OccW'(count_d);
    end
  end

  assign status_o        = status_q;
  assign head_value_o    = hv_q;
  assign head_priority_o = hp_q;
  assign occupancy_o     = occ_q;

endmodule

[rtl/sorted_priority_queue.sv]
// top level of the sorted priority queue
//
//  channel | signals                                           | direction
//  --------+---------------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, command_i, item_value_i,  | input
//          | item_priority_i                                   |
//  out     | out_valid_o, out_ready_i, status_o, head_value_o, | output
//          | head_priority_o, occupancy_o                      |
//
// each transaction is first captured; then, on insert, every cell compares
// against the new priority in parallel and shifts, and on remove the cells shift.
// a new transaction is taken while the previous result still waits; the
// update cycle holds until the result register is free.
// reset clears the fill count, the controller state and the result valid;
// cell contents are don't-care until written.
module sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QueueDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             command_i,
  input  logic signed [spq_pkg::DataW-1:0] item_value_i,
  input  logic signed [spq_pkg::DataW-1:0] item_priority_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic signed [spq_pkg::DataW-1:0] head_value_o,
  output logic signed [spq_pkg::DataW-1:0] head_priority_o,
  output logic [spq_pkg::OccW-1:0]         occupancy_o
);
  import spq_pkg::*;

  dp_cmd_t dp_cmd;

  // sequencing and handshakes
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd)
  );

  // cells and result register
  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .command_i       (command_i),
    .item_value_i    (item_value_i),
    .item_priority_i (item_priority_i),
    .status_o        (status_o),
    .head_value_o    (head_value_o),
    .head_priority_o (head_priority_o),
    .occupancy_o     (occupancy_o)
  );

endmodule

[rtl/spq_checker.sv]
// port-level checks of the sorted priority queue, bound to the top level
module spq_port_checks #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QueueDepthDef
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             command_i,
  input logic signed [spq_pkg::DataW-1:0] item_value_i,
  input logic signed [spq_pkg::DataW-1:0] item_priority_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [1:0]                       status_o,
  input logic signed [spq_pkg::DataW-1:0] head_value_o,
  input logic signed [spq_pkg::DataW-1:0] head_priority_o,
  input logic [spq_pkg::OccW-1:0]         occupancy_o
);
  import spq_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(head_value_o) && $stable(head_priority_o) && $stable(occupancy_o))
    else $error("result changed while stalled");

  // dropped insert reports no entry
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_FULL |-> head_value_o == '0 && head_priority_o == '0)
    else $error("full status with nonzero entry");

  // full status only at full occupancy
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_FULL |-> occupancy_o == OccW'(QUEUE_DEPTH))
    else $error("full status with wrong occupancy");

  // empty remove leaves nothing and reports nothing
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_EMPTY |->
      occupancy_o == '0 && head_value_o == '0 && head_priority_o == '0)
    else $error("empty status with entry or occupancy");

endmodule

bind sorted_priority_queue spq_port_checks #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (.*);
